### hw/rtl/zigzag_diagonal_scan_generator_top_defines.svh
// Assertion macros shared by the zigzag scan RTL.
// Each check is clocked on clock and held off during reset.
`ifndef ZIGZAG_DIAGONAL_SCAN_GENERATOR_TOP_DEFINES_SVH
`define ZIGZAG_DIAGONAL_SCAN_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define ZDS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ZDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/zds_pkg.sv
package zds_pkg;

   // Grid side limit; a dimension above it is clamped to it.
   localparam int MAX_DIM = 256;
   localparam logic [8:0] DIM_LIMIT = 9'((MAX_DIM < 256) ? MAX_DIM : 256);

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ROW_COUNT = 2'd0,
      REG_COL_COUNT = 2'd1,
      REG_EVEN_UP   = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [8:0] rows;      // effective, 1..DIM_LIMIT
      logic [8:0] cols;      // effective, 1..DIM_LIMIT
      logic       even_up;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  cell_row;
      logic [7:0]  cell_col;
      logic [16:0] seq_number;
      logic        last_cell;
   } result_type;

   function automatic logic [8:0] eff_dim(input logic [8:0] v);
      logic [8:0] r;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (v > DIM_LIMIT) begin
         r = DIM_LIMIT;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### hw/rtl/zds_csr.sv
module zds_csr
   import zds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   logic [8:0] row_count_ff, row_count_in;
   logic [8:0] col_count_ff, col_count_in;
   logic       even_up_ff, even_up_in;
   logic       wr_en;
   reg_index_type idx;

   assign idx   = reg_index_type'(paddr[3:2]);
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      even_up_in   = even_up_ff;
      if (wr_en) begin
         case (idx)
            REG_ROW_COUNT: row_count_in = pwdata[8:0];
            REG_COL_COUNT: col_count_in = pwdata[8:0];
            REG_EVEN_UP:   even_up_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROW_COUNT: prdata = {23'd0, row_count_ff};
         REG_COL_COUNT: prdata = {23'd0, col_count_ff};
         REG_EVEN_UP:   prdata = {31'd0, even_up_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 9'd8;
         col_count_ff <= 9'd8;
         even_up_ff   <= 1'b1;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         even_up_ff   <= even_up_in;
      end
   end

   assign cfg.rows    = eff_dim(row_count_ff);
   assign cfg.cols    = eff_dim(col_count_ff);
   assign cfg.even_up = even_up_ff;

endmodule

### hw/rtl/zds_walk.sv
module zds_walk
   import zds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       restart,
   input  cfg_type    cfg,
   output result_type result
);

   `include "zigzag_diagonal_scan_generator_top_defines.svh"

   logic [8:0]  diag_ff, diag_in;
   logic [7:0]  row_ff, row_in;
   logic [7:0]  col_ff, col_in;
   logic [16:0] seq_ff, seq_in;

   logic [8:0]  last_diag, rows_m1, cols_m1;
   logic        go_start;
   logic [8:0]  s, s1, lim1;
   logic [7:0]  r, c;
   logic [16:0] q;
   logic        last, up;
   logic        step_up_ok, step_dn_ok;

   assign last_diag = cfg.rows + cfg.cols - 9'd2;
   assign rows_m1   = cfg.rows - 9'd1;
   assign cols_m1   = cfg.cols - 9'd1;

   // Restart, or the held cell no longer fits the grid: fall back to cell zero.
   assign go_start = restart
                  || ({1'b0, row_ff} >= cfg.rows)
                  || ({1'b0, col_ff} >= cfg.cols)
                  || (({1'b0, row_ff} + {1'b0, col_ff}) != diag_ff)
                  || (diag_ff > last_diag);

   assign s = go_start ? 9'd0 : diag_ff;
   assign r = go_start ? 8'd0 : row_ff;
   assign c = go_start ? 8'd0 : col_ff;
   assign q = go_start ? 17'd1 : seq_ff;

   assign last = (s == last_diag);
   assign up   = ((s[0] == 1'b0) == cfg.even_up);

   assign step_up_ok = (r != 8'd0) && ({1'b0, c} < cols_m1);
   assign step_dn_ok = (c != 8'd0) && ({1'b0, r} < rows_m1);

   // Entry of the next diagonal; its direction is the opposite of this one.
   assign s1   = s + 9'd1;
   assign lim1 = !up ? ((s1 < rows_m1) ? s1 : rows_m1)
                     : ((s1 < cols_m1) ? s1 : cols_m1);

   always_comb begin
      diag_in = s;
      row_in  = r;
      col_in  = c;
      seq_in  = q + 17'd1;
      if (last) begin
         diag_in = 9'd0;
         row_in  = 8'd0;
         col_in  = 8'd0;
         seq_in  = 17'd1;
      end else if (up && step_up_ok) begin
         row_in = r - 8'd1;
         col_in = c + 8'd1;
      end else if (!up && step_dn_ok) begin
         row_in = r + 8'd1;
         col_in = c - 8'd1;
      end else begin
         diag_in = s1;
         if (!up) begin
            row_in = lim1[7:0];
            col_in = 8'(s1 - lim1);
         end else begin
            col_in = lim1[7:0];
            row_in = 8'(s1 - lim1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff <= 9'd0;
         row_ff  <= 8'd0;
         col_ff  <= 8'd0;
         seq_ff  <= 17'd1;
      end else if (accept) begin
         diag_ff <= diag_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         seq_ff  <= seq_in;
      end
   end

   assign result.cell_row   = r;
   assign result.cell_col   = c;
   assign result.seq_number = q;
   assign result.last_cell  = last;

   `ZDS_ASSERT_NEXT(a_wrap_after_last, accept && last, (seq_ff == 17'd1) && (diag_ff == 9'd0), "scan did not wrap after last cell")
   `ZDS_ASSERT_NOW(a_restart_zero, restart, (s == 9'd0) && (q == 17'd1), "restart did not select cell zero")

endmodule

### hw/rtl/zds_out.sv
module zds_out
   import zds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       in_stall,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   `include "zigzag_diagonal_scan_generator_top_defines.svh"

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take, accept;

   assign take   = out_valid_ff && !out_stall;
   assign accept = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `ZDS_ASSERT_NOW(a_skid_implies_out, skid_valid_ff, out_valid_ff, "skid holds data while output empty")
   `ZDS_ASSERT_NEXT(a_skid_fills, accept && out_valid_ff && out_stall, skid_valid_ff, "stalled transaction not parked in skid")

endmodule

### hw/rtl/zigzag_diagonal_scan_generator_top.sv
// Zigzag scan coordinate generator for a row_count x col_count grid.
// Each accepted request's response is registered before it shows on rsp_*.
// Throughput: one transaction per cycle while req_stall is low; the next cell
// is computed in the same cycle from the held cell, and a two-entry output
// (register + skid) absorbs stalls. Reset (synchronous, active high): scan at
// cell zero with sequence 1, grid 8 x 8, even diagonals upward, output empty.
module zigzag_diagonal_scan_generator_top
   import zds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_restart,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_cell_row,
   output logic [7:0]        rsp_cell_col,
   output logic [16:0]       rsp_seq_number,
   output logic              rsp_last_cell,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   result_type walk_result;
   result_type rsp_data;
   logic       req_accept;

   // Register file; zero-wait, so pready is tied high.
   assign csr_pready = 1'b1;

   zds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // The request is taken whenever the skid entry is free; the walker
   // state advances on the same edge, so no request waits on the result.
   assign req_accept = req_valid && !req_stall;

   zds_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .restart (req_restart),
      .cfg     (cfg),
      .result  (walk_result)
   );

   // Output register plus skid; req_stall comes from a flop only.
   zds_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (walk_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_cell_row   = rsp_data.cell_row;
   assign rsp_cell_col   = rsp_data.cell_col;
   assign rsp_seq_number = rsp_data.seq_number;
   assign rsp_last_cell  = rsp_data.last_cell;

endmodule
